@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the rtl of the gcr byte codec
// expects a clock named clk and an active-low reset named rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/gcr_pkg.sv @@
// package for the gcr byte codec: command codes, result record and code tables
// no dependencies
`default_nettype none

package gcr_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_DECODE = 2'd2;

    localparam logic [7:0] BAD_NIBBLE = 8'hff;

    localparam logic [4:0] ENC_BITS  = 5'd10;
    localparam logic [4:0] DEC_BITS  = 5'd8;
    localparam logic [4:0] BYTE_BITS = 5'd8;

    typedef struct packed {
        logic [7:0] data;
        logic       code_valid;
        logic       last;
        logic       acc_empty;
    } result_t;

    // 4-bit nibble to 5-bit group code
    function automatic logic [4:0] nib_to_code(input logic [3:0] nib);
        logic [4:0] code;
        case (nib)
            4'h0:    code = 5'h0a;
            4'h1:    code = 5'h0b;
            4'h2:    code = 5'h12;
            4'h3:    code = 5'h13;
            4'h4:    code = 5'h0e;
            4'h5:    code = 5'h0f;
            4'h6:    code = 5'h16;
            4'h7:    code = 5'h17;
            4'h8:    code = 5'h09;
            4'h9:    code = 5'h19;
            4'ha:    code = 5'h1a;
            4'hb:    code = 5'h1b;
            4'hc:    code = 5'h0d;
            4'hd:    code = 5'h1d;
            4'he:    code = 5'h1e;
            default: code = 5'h15;
        endcase
        return code;
    endfunction

    // 5-bit group code to nibble, BAD_NIBBLE for codes outside the table
    function automatic logic [7:0] code_to_nib(input logic [4:0] code);
        logic [7:0] nib;
        case (code)
            5'h09:   nib = 8'h08;
            5'h0a:   nib = 8'h00;
            5'h0b:   nib = 8'h01;
            5'h0d:   nib = 8'h0c;
            5'h0e:   nib = 8'h04;
            5'h0f:   nib = 8'h05;
            5'h12:   nib = 8'h02;
            5'h13:   nib = 8'h03;
            5'h15:   nib = 8'h0f;
            5'h16:   nib = 8'h06;
            5'h17:   nib = 8'h07;
            5'h19:   nib = 8'h09;
            5'h1a:   nib = 8'h0a;
            5'h1b:   nib = 8'h0b;
            5'h1d:   nib = 8'h0d;
            5'h1e:   nib = 8'h0e;
            default: nib = BAD_NIBBLE;
        endcase
        return nib;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gcr_byte_codec.sv @@
// gcr byte codec top level: 4-to-5 group code encoder and decoder on one bit accumulator
// depends on gcr_pkg and assert_macros.svh
//
// usage
//   input channel  in_valid / in_ready carries command and data_in; a transfer
//   happens at a rising clk edge with both high. command clear empties the
//   accumulator, encode turns one byte into a 10-bit code and drains every full
//   byte, decode appends one code byte and yields a decoded byte once 10 bits
//   are held. an unused command code is dropped with no effect.
//   output channel out_valid / out_ready carries data_out, code_valid, last and
//   accumulator_empty; last marks the final result of an input transfer.
//   an input waits in the input register, then its results go to the result slots.
//   throughput: one input per cycle while out_ready is high and each input gives
//   at most one result; an input with two results holds the next one back until
//   its first result has left. the limit is the single result register on the
//   output port.
//   no bubble while out_ready stays high: the input register frees as slots drain
//   reset (rst_n low, asynchronous) empties the accumulator and drops all
//   queued results. a stalled receiver holds the current result steady; one
//   more input is taken into the input register and then in_ready falls.
`default_nettype none
`include "assert_macros.svh"

module gcr_byte_codec (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] command,
    input  wire logic [7:0] data_in,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      data_out,
    output logic            code_valid,
    output logic            last,
    output logic            accumulator_empty
);

    // input register
    logic       item_valid_reg;
    logic [1:0] item_cmd_reg;
    logic [7:0] item_data_reg;

    // bit accumulator, oldest bit in bit 0
    logic [15:0] acc_reg, acc_next;
    logic [4:0]  cnt_reg, cnt_next;

    // result slots; slot0 drives the output port
    logic [1:0]        out_cnt_reg, out_cnt_next;
    gcr_pkg::result_t  slot0_reg, slot0_next;
    gcr_pkg::result_t  slot1_reg, slot1_next;

    logic load_ok;
    logic item_move;
    logic out_pop;

    // results of the item in the input register
    logic [1:0]       res_n;
    gcr_pkg::result_t res0, res1;

    logic [9:0]  code10;
    logic [15:0] ins_bits;
    logic [15:0] acc1, acc2;
    logic [4:0]  cnt1, cnt2;
    logic [7:0]  hi_nib, lo_nib;

    // handshake control
    assign load_ok   = (out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && out_ready);
    assign item_move = item_valid_reg && load_ok;
    assign in_ready  = !item_valid_reg || load_ok;
    assign out_valid = (out_cnt_reg != 2'd0);
    assign out_pop   = out_valid && out_ready;

    assign data_out          = slot0_reg.data;
    assign code_valid        = slot0_reg.code_valid;
    assign last              = slot0_reg.last;
    assign accumulator_empty = slot0_reg.acc_empty;

    // single pass over the accumulator for one item
    always_comb
    begin
        code10   = {gcr_pkg::nib_to_code(item_data_reg[7:4]),
                    gcr_pkg::nib_to_code(item_data_reg[3:0])};
        ins_bits = (item_cmd_reg == gcr_pkg::CMD_ENCODE) ? {6'd0, code10}
                                                          : {8'd0, item_data_reg};
        // bits shifted past bit 15 are dropped while the count keeps them
        acc1     = acc_reg | (ins_bits << cnt_reg);
        cnt1     = cnt_reg + ((item_cmd_reg == gcr_pkg::CMD_ENCODE) ? gcr_pkg::ENC_BITS
                                                                     : gcr_pkg::DEC_BITS);
        acc2     = {8'd0, acc1[15:8]};
        cnt2     = cnt1 - gcr_pkg::BYTE_BITS;
        hi_nib   = gcr_pkg::code_to_nib(acc1[9:5]);
        lo_nib   = gcr_pkg::code_to_nib(acc1[4:0]);

        res_n    = 2'd0;
        res0     = '0;
        res1     = '0;
        acc_next = acc_reg;
        cnt_next = cnt_reg;

        case (item_cmd_reg)
            gcr_pkg::CMD_CLEAR:
            begin
                acc_next = '0;
                cnt_next = '0;
            end
            gcr_pkg::CMD_ENCODE:
            begin
                // at least ten bits are held, so one byte always drains
                res0.data       = acc1[7:0];
                res0.code_valid = 1'b1;
                res0.acc_empty  = (cnt2 == 5'd0);
                if (cnt2 >= gcr_pkg::BYTE_BITS)
                begin
                    res_n           = 2'd2;
                    res0.last       = 1'b0;
                    res1.data       = acc2[7:0];
                    res1.code_valid = 1'b1;
                    res1.last       = 1'b1;
                    res1.acc_empty  = (cnt2 == gcr_pkg::BYTE_BITS);
                    acc_next        = {8'd0, acc2[15:8]};
                    cnt_next        = cnt2 - gcr_pkg::BYTE_BITS;
                end
                else
                begin
                    res_n     = 2'd1;
                    res0.last = 1'b1;
                    acc_next  = acc2;
                    cnt_next  = cnt2;
                end
            end
            gcr_pkg::CMD_DECODE:
            begin
                if (cnt1 >= gcr_pkg::ENC_BITS)
                begin
                    res_n           = 2'd1;
                    // a bad high code leaves 0xf in the top nibble, a bad low code forces 0xff
                    res0.data       = {hi_nib[3:0], 4'd0} | lo_nib;
                    res0.code_valid = (hi_nib != gcr_pkg::BAD_NIBBLE) &&
                                      (lo_nib != gcr_pkg::BAD_NIBBLE);
                    res0.last       = 1'b1;
                    res0.acc_empty  = (cnt1 == gcr_pkg::ENC_BITS);
                    acc_next        = {10'd0, acc1[15:10]};
                    cnt_next        = cnt1 - gcr_pkg::ENC_BITS;
                end
                else
                begin
                    acc_next = acc1;
                    cnt_next = cnt1;
                end
            end
            default:
            begin
                // unused command code: no result, no change
                acc_next = acc_reg;
                cnt_next = cnt_reg;
            end
        endcase
    end

    // result slot update
    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        slot0_next   = slot0_reg;
        slot1_next   = slot1_reg;
        if (item_move)
        begin
            out_cnt_next = res_n;
            slot0_next   = res0;
            slot1_next   = res1;
        end
        else if (out_pop)
        begin
            if (out_cnt_reg == 2'd2)
            begin
                out_cnt_next = 2'd1;
                slot0_next   = slot1_reg;
            end
            else
            begin
                out_cnt_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (item_move)
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
            end
            out_cnt_reg <= out_cnt_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_cmd_reg  <= command;
            item_data_reg <= data_in;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // checks
    `ASSERT_NEVER(a_cnt_bound, cnt_reg > 5'd9, "held bit count above nine between items")
    `ASSERT_NEVER(a_slot_cnt, out_cnt_reg == 2'd3, "more than two queued results")
    `ASSERT_CLK(a_pair_order, (out_cnt_reg == 2'd2) |-> (!slot0_reg.last && slot1_reg.last),
                "result pair marked out of order")
    `ASSERT_CLK(a_in_taken, (in_valid && in_ready) |=> item_valid_reg, "input transfer lost")
    `ASSERT_CLK(a_pop_pair, (out_cnt_reg == 2'd2 && out_ready) |=> (out_cnt_reg == 2'd1),
                "second result dropped")

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking testbench for gcr_byte_codec: directed table, then random traffic under idling
// depends on gcr_pkg and the gcr_byte_codec rtl; outputs are checked against an in-bench predictor
`timescale 1ns / 100ps

module tb_top;

    // the one command code the block drops without effect
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // nibble to 5-bit group code, entry 15 first
    localparam logic [15:0][4:0] GCR_CODE = {
        5'h15, 5'h1e, 5'h1d, 5'h0d, 5'h1b, 5'h1a, 5'h19, 5'h09,
        5'h17, 5'h16, 5'h0f, 5'h0e, 5'h13, 5'h12, 5'h0b, 5'h0a
    };

    // 5-bit group code back to nibble, entry 31 first
    localparam logic [31:0][7:0] GCR_NIBBLE = {
        gcr_pkg::BAD_NIBBLE, 8'h0e, 8'h0d, gcr_pkg::BAD_NIBBLE,
        8'h0b, 8'h0a, 8'h09, gcr_pkg::BAD_NIBBLE,
        8'h07, 8'h06, 8'h0f, gcr_pkg::BAD_NIBBLE,
        8'h03, 8'h02, gcr_pkg::BAD_NIBBLE, gcr_pkg::BAD_NIBBLE,
        8'h05, 8'h04, 8'h0c, gcr_pkg::BAD_NIBBLE,
        8'h01, 8'h00, 8'h08, gcr_pkg::BAD_NIBBLE,
        gcr_pkg::BAD_NIBBLE, gcr_pkg::BAD_NIBBLE, gcr_pkg::BAD_NIBBLE, gcr_pkg::BAD_NIBBLE,
        gcr_pkg::BAD_NIBBLE, gcr_pkg::BAD_NIBBLE, gcr_pkg::BAD_NIBBLE, gcr_pkg::BAD_NIBBLE
    };

    localparam gcr_pkg::result_t NO_RESULT = '0;

    // one row of the directed table; typed rows carry their results in the row itself
    typedef struct {
        logic [1:0]       cmd;
        logic [7:0]       data;
        bit               typed;
        int               count;
        gcr_pkg::result_t first;
        gcr_pkg::result_t second;
    } stim_row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] command   = gcr_pkg::CMD_CLEAR;
    logic [7:0] data_in   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_out;
    logic       code_valid;
    logic       last;
    logic       accumulator_empty;

    // predictor copy of the accumulator
    logic [15:0] pred_acc  = '0;
    logic [4:0]  pred_held = '0;

    // stream of well-formed code bits used to feed aligned decodes
    logic [31:0] code_stream     = '0;
    int          code_stream_len = 0;

    gcr_pkg::result_t awaited_results [$];
    stim_row_t        directed_rows [$];
    gcr_pkg::result_t head_result;

    int send_idle_pct  = 28;
    int recv_idle_pct  = 83;
    int mismatch_count = 0;
    int result_count   = 0;

    gcr_byte_codec DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .command           (command),
        .data_in           (data_in),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .data_out          (data_out),
        .code_valid        (code_valid),
        .last              (last),
        .accumulator_empty (accumulator_empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("gcr_byte_codec verification failed");
        $finish;
    end

    task automatic note_error(input string msg);
        $display("%0t  %s", $time, msg);
        mismatch_count++;
    endtask

    // advance the predicted accumulator by one input and queue the results it causes
    task automatic gcr_predict(input logic [1:0] cmd, input logic [7:0] byt);
        logic [31:0]      wide;
        logic [9:0]       code;
        logic [7:0]       hi_nib;
        logic [7:0]       lo_nib;
        logic [11:0]      merged;
        gcr_pkg::result_t r;
        int               n;
        n = 0;
        case (cmd)
            gcr_pkg::CMD_CLEAR:
            begin
                pred_acc  = '0;
                pred_held = '0;
            end
            gcr_pkg::CMD_ENCODE:
            begin
                code      = {GCR_CODE[byt[7:4]], GCR_CODE[byt[3:0]]};
                // bits shifted past bit 15 are lost, the count still holds them
                wide      = {16'h0, pred_acc} | ({22'h0, code} << pred_held);
                pred_acc  = wide[15:0];
                pred_held = pred_held + gcr_pkg::ENC_BITS;
                while (pred_held >= gcr_pkg::BYTE_BITS && n < 2)
                begin
                    r.data       = pred_acc[7:0];
                    pred_acc     = pred_acc >> 8;
                    pred_held    = pred_held - gcr_pkg::BYTE_BITS;
                    n++;
                    r.code_valid = 1'b1;
                    r.acc_empty  = (pred_held == 0);
                    r.last       = !(pred_held >= gcr_pkg::BYTE_BITS && n < 2);
                    awaited_results.push_back(r);
                end
            end
            gcr_pkg::CMD_DECODE:
            begin
                wide      = {16'h0, pred_acc} | ({24'h0, byt} << pred_held);
                pred_acc  = wide[15:0];
                pred_held = pred_held + gcr_pkg::DEC_BITS;
                if (pred_held >= gcr_pkg::ENC_BITS)
                begin
                    hi_nib       = GCR_NIBBLE[pred_acc[9:5]];
                    lo_nib       = GCR_NIBBLE[pred_acc[4:0]];
                    // a bad high code leaves f0, a bad low code forces ff
                    merged       = {hi_nib, 4'h0} | {4'h0, lo_nib};
                    r.data       = merged[7:0];
                    r.code_valid = (hi_nib != gcr_pkg::BAD_NIBBLE) &&
                                   (lo_nib != gcr_pkg::BAD_NIBBLE);
                    pred_acc     = pred_acc >> 10;
                    pred_held    = pred_held - gcr_pkg::ENC_BITS;
                    r.last       = 1'b1;
                    r.acc_empty  = (pred_held == 0);
                    awaited_results.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // drive one input and return at the edge where it transfers
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] byt);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        data_in  <= byt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic apply_item(input logic [1:0] cmd, input logic [7:0] byt);
        send_item(cmd, byt);
        gcr_predict(cmd, byt);
    endtask

    // hold the sender off until every queued result has come out
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [1:0] cmd, input logic [7:0] byt, input bit typed,
                           input int count, input gcr_pkg::result_t first,
                           input gcr_pkg::result_t second);
        stim_row_t row;
        row.cmd    = cmd;
        row.data   = byt;
        row.typed  = typed;
        row.count  = count;
        row.first  = first;
        row.second = second;
        directed_rows.push_back(row);
    endtask

    // random traffic: mostly aligned decodes of real codes and encodes, some noise
    task automatic run_phase(input int send_pct, input int recv_pct, input int items);
        int         pick;
        logic [1:0] cmd;
        logic [7:0] byt;
        logic [7:0] pair;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(99);
            byt  = 8'($urandom_range(255));
            if (pick < 8)
            begin
                // clear realigns the decoder with the code stream
                cmd             = gcr_pkg::CMD_CLEAR;
                code_stream     = '0;
                code_stream_len = 0;
            end
            else if (pick < 12)
                cmd = CMD_UNUSED;
            else if (pick < 52)
                cmd = gcr_pkg::CMD_ENCODE;
            else if (pick < 88)
            begin
                cmd = gcr_pkg::CMD_DECODE;
                if (code_stream_len < 8)
                begin
                    pair            = 8'($urandom_range(255));
                    code_stream     = code_stream | ({22'h0, GCR_CODE[pair[7:4]],
                                      GCR_CODE[pair[3:0]]} << code_stream_len);
                    code_stream_len = code_stream_len + 10;
                end
                byt             = code_stream[7:0];
                code_stream     = code_stream >> 8;
                code_stream_len = code_stream_len - 8;
            end
            else
                cmd = gcr_pkg::CMD_DECODE;
            apply_item(cmd, byt);
        end
    endtask

    // receiver stalls at random
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
                note_error($sformatf("result %0d: data %02h with nothing expected",
                                     result_count, data_out));
            else
            begin
                head_result = awaited_results.pop_front();
                if (data_out !== head_result.data)
                    note_error($sformatf("result %0d: data_out %02h, want %02h",
                                         result_count, data_out, head_result.data));
                if (code_valid !== head_result.code_valid)
                    note_error($sformatf("result %0d: code_valid %b, want %b",
                                         result_count, code_valid, head_result.code_valid));
                if (last !== head_result.last)
                    note_error($sformatf("result %0d: last %b, want %b",
                                         result_count, last, head_result.last));
                if (accumulator_empty !== head_result.acc_empty)
                    note_error($sformatf("result %0d: accumulator_empty %b, want %b",
                                         result_count, accumulator_empty,
                                         head_result.acc_empty));
            end
            result_count++;
        end
    end

    initial
    begin
        stim_row_t        row;
        gcr_pkg::result_t scratch;
        int               depth;

        // typed rows: result fields are data, code_valid, last, accumulator_empty
        add_row(gcr_pkg::CMD_CLEAR,  8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        // all-zero byte encodes to 14a, low byte goes out, two bits stay
        add_row(gcr_pkg::CMD_ENCODE, 8'h00, 1'b1, 1, {8'h4a, 1'b1, 1'b1, 1'b0}, NO_RESULT);
        add_row(gcr_pkg::CMD_CLEAR,  8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_ENCODE, 8'hff, 1'b1, 1, {8'hb5, 1'b1, 1'b1, 1'b0}, NO_RESULT);
        // unused command leaves the two held bits alone
        add_row(CMD_UNUSED,          8'ha5, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_CLEAR,  8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        // short decode gives nothing, the second byte yields two bad codes
        add_row(gcr_pkg::CMD_DECODE, 8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_DECODE, 8'h00, 1'b1, 1, {8'hff, 1'b0, 1'b1, 1'b0}, NO_RESULT);
        add_row(gcr_pkg::CMD_CLEAR,  8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_DECODE, 8'hff, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_DECODE, 8'hff, 1'b1, 1, {8'hff, 1'b0, 1'b1, 1'b0}, NO_RESULT);
        add_row(gcr_pkg::CMD_CLEAR,  8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        // well-formed code 14a decodes to zero
        add_row(gcr_pkg::CMD_DECODE, 8'h4a, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_DECODE, 8'h01, 1'b1, 1, {8'h00, 1'b1, 1'b1, 1'b0}, NO_RESULT);
        add_row(gcr_pkg::CMD_CLEAR,  8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        // bad high code only
        add_row(gcr_pkg::CMD_DECODE, 8'h0a, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_DECODE, 8'h00, 1'b1, 1, {8'hf0, 1'b0, 1'b1, 1'b0}, NO_RESULT);
        add_row(gcr_pkg::CMD_CLEAR,  8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        // bad low code only
        add_row(gcr_pkg::CMD_DECODE, 8'h40, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_DECODE, 8'h01, 1'b1, 1, {8'hff, 1'b0, 1'b1, 1'b0}, NO_RESULT);
        add_row(gcr_pkg::CMD_CLEAR,  8'h00, 1'b1, 0, NO_RESULT, NO_RESULT);
        // encode on top of eight decode bits overflows the accumulator
        add_row(gcr_pkg::CMD_DECODE, 8'hc3, 1'b1, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_ENCODE, 8'hff, 1'b1, 2, {8'hc3, 1'b1, 1'b0, 1'b0},
                {8'hb5, 1'b1, 1'b1, 1'b0});
        // encodes until the accumulator runs empty on a two-byte drain
        add_row(gcr_pkg::CMD_ENCODE, 8'h5a, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_ENCODE, 8'h3c, 1'b0, 0, NO_RESULT, NO_RESULT);
        add_row(gcr_pkg::CMD_ENCODE, 8'h81, 1'b0, 0, NO_RESULT, NO_RESULT);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 28;
        recv_idle_pct = 83;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (!row.typed)
                apply_item(row.cmd, row.data);
            else
            begin
                // keep the predictor in step but check against the typed results
                send_item(row.cmd, row.data);
                depth = awaited_results.size();
                gcr_predict(row.cmd, row.data);
                while (awaited_results.size() > depth)
                    scratch = awaited_results.pop_back();
                if (row.count > 0)
                    awaited_results.push_back(row.first);
                if (row.count > 1)
                    awaited_results.push_back(row.second);
            end
        end
        drain_results();

        run_phase(28, 83, 347);
        drain_results();
        run_phase(83, 28, 347);
        drain_results();
        run_phase(0, 0, 347);
        drain_results();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("gcr_byte_codec verification clean");
        else
            $display("gcr_byte_codec verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/gcr_pkg.sv
hw/rtl/gcr_byte_codec.sv
dv/tb_top.sv
